// ===== sv/tpc_pkg.sv =====
// Shared constants for the three-point curvature core and its checker.
// No dependencies.
package tpc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int OUT_W           = 32;
    localparam int USER_W          = 2;
    localparam int USER_DEGEN      = 0;
    localparam int USER_SAT        = 1;

endpackage

// ===== sv/three_point_curvature_core.sv =====
// Three-point curvature core: circumcircle curvature from three fixed-point points.
// Depends on tpc_pkg.
//
// Each input transfer passes through the stages listed below before its result is loaded into
// the output register; the output transfer can take place at the next edge.
// Throughput: one item per cycle; the datapath is a single-enable pipeline of
// 7 arithmetic stages, a saturation check, 64 restoring-division stages and
// 32 square-root stages. The whole pipeline holds while the output waits.
// Reset (i_rst_n, synchronous, active low) clears all valid bits.
module three_point_curvature_core #(
    parameter int COORD_WIDTH = tpc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tpc_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // first_x, first_y, middle_x, middle_y, last_x, last_y, zero fill
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // curvature
    output logic [tpc_pkg::OUT_W-1:0]             m_axis_tdata,
    // degenerate, saturated
    output logic [tpc_pkg::USER_W-1:0]            m_axis_tuser
);
    import tpc_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int D    = CW + 1;
    localparam int PW   = 2 * D;
    localparam int SW   = PW + 1;
    localparam int C2W  = 2 * SW;
    localparam int DW   = 3 * SW;
    localparam int RW   = DW + 1;
    localparam int SH   = 4 * FRAC_BITS + 2;
    localparam int NW   = C2W + SH;
    localparam int QB   = 2 * OUT_W;
    localparam int PPW  = 2 * D + 3;
    localparam int NDIV = QB;
    localparam int NSQ  = OUT_W;

    logic en;

    logic                r_out_vld;
    logic [OUT_W-1:0]    r_out_data;
    logic [USER_W-1:0]   r_out_user;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: differences and magnitudes.
    logic signed [CW-1:0] c_pt  [6];
    logic signed [D-1:0]  c_dif [6];
    logic [D-1:0]         n1_mag [6];
    logic [D-1:0]         r1_mag [6];
    logic [3:0]           r1_neg;
    logic [6:0]           r_fv;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            c_pt[k] = s_axis_tdata[k*CW +: CW];
        end
        c_dif[0] = D'(c_pt[2]) - D'(c_pt[0]);
        c_dif[1] = D'(c_pt[3]) - D'(c_pt[1]);
        c_dif[2] = D'(c_pt[4]) - D'(c_pt[0]);
        c_dif[3] = D'(c_pt[5]) - D'(c_pt[1]);
        c_dif[4] = D'(c_pt[4]) - D'(c_pt[2]);
        c_dif[5] = D'(c_pt[5]) - D'(c_pt[3]);
        for (int k = 0; k < 6; k++) begin
            n1_mag[k] = c_dif[k][D-1] ? D'(-c_dif[k]) : D'(c_dif[k]);
        end
    end

    // Stages 2..7 registers.
    logic [PW-1:0]    r2_p1, r2_p2;
    logic [PW-1:0]    r2_sq [6];
    logic             r2_same;
    logic [SW-1:0]    r3_cr, r3_a2, r3_b2, r3_c2;
    logic [2*D-1:0]   r4_crll, r4_abll;
    logic [2*D:0]     r4_crlh, r4_ablh, r4_abhl;
    logic [2*D+1:0]   r4_crhh, r4_abhh;
    logic [SW-1:0]    r4_c2;
    logic             r4_deg;
    logic [C2W-1:0]   r5_cr2, r5_ab;
    logic [SW-1:0]    r5_c2;
    logic             r5_deg;
    logic [PPW-1:0]   r6_pp [8];
    logic [C2W-1:0]   r6_cr2;
    logic             r6_deg;
    logic [DW-1:0]    r7_den;
    logic [C2W-1:0]   r7_cr2;
    logic             r7_deg;

    logic [D+1:0]     c_abl [4];
    logic [D:0]       c_c2l [2];
    logic [DW-1:0]    n7_den;

    always_comb begin
        c_abl[0] = {2'b00, r5_ab[D-1:0]};
        c_abl[1] = {2'b00, r5_ab[2*D-1:D]};
        c_abl[2] = {2'b00, r5_ab[3*D-1:2*D]};
        c_abl[3] = r5_ab[C2W-1:3*D];
        c_c2l[0] = {1'b0, r5_c2[D-1:0]};
        c_c2l[1] = r5_c2[SW-1:D];
        n7_den   = '0;
        for (int k = 0; k < 8; k++) begin
            n7_den = n7_den + (DW'(r6_pp[k]) << (((k >> 1) + (k & 1)) * D));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (en) begin
            r_fv <= {r_fv[5:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mag <= n1_mag;
            r1_neg <= {c_dif[3][D-1], c_dif[2][D-1], c_dif[1][D-1], c_dif[0][D-1]};

            r2_p1   <= r1_mag[0] * r1_mag[3];
            r2_p2   <= r1_mag[1] * r1_mag[2];
            for (int k = 0; k < 6; k++) begin
                r2_sq[k] <= r1_mag[k] * r1_mag[k];
            end
            r2_same <= (r1_neg[0] ^ r1_neg[3]) == (r1_neg[1] ^ r1_neg[2]);

            if (!r2_same) begin
                r3_cr <= SW'(r2_p1) + SW'(r2_p2);
            end else if (r2_p1 >= r2_p2) begin
                r3_cr <= SW'(r2_p1) - SW'(r2_p2);
            end else begin
                r3_cr <= SW'(r2_p2) - SW'(r2_p1);
            end
            r3_a2 <= SW'(r2_sq[0]) + SW'(r2_sq[1]);
            r3_b2 <= SW'(r2_sq[4]) + SW'(r2_sq[5]);
            r3_c2 <= SW'(r2_sq[2]) + SW'(r2_sq[3]);

            r4_crll <= r3_cr[D-1:0] * r3_cr[D-1:0];
            r4_crlh <= r3_cr[D-1:0] * r3_cr[SW-1:D];
            r4_crhh <= r3_cr[SW-1:D] * r3_cr[SW-1:D];
            r4_abll <= r3_a2[D-1:0] * r3_b2[D-1:0];
            r4_ablh <= r3_a2[D-1:0] * r3_b2[SW-1:D];
            r4_abhl <= r3_a2[SW-1:D] * r3_b2[D-1:0];
            r4_abhh <= r3_a2[SW-1:D] * r3_b2[SW-1:D];
            r4_c2   <= r3_c2;
            r4_deg  <= (r3_cr == '0);

            r5_cr2 <= C2W'(r4_crll) + (C2W'(r4_crlh) << (D + 1))
                    + (C2W'(r4_crhh) << (2 * D));
            r5_ab  <= C2W'(r4_abll) + ((C2W'(r4_ablh) + C2W'(r4_abhl)) << D)
                    + (C2W'(r4_abhh) << (2 * D));
            r5_c2  <= r4_c2;
            r5_deg <= r4_deg;

            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 2; j++) begin
                    r6_pp[i*2+j] <= c_abl[i] * c_c2l[j];
                end
            end
            r6_cr2 <= r5_cr2;
            r6_deg <= r5_deg;

            r7_den <= n7_den;
            r7_cr2 <= r6_cr2;
            r7_deg <= r6_deg;
        end
    end

    // Division pipeline; index 0 is the saturation check stage.
    logic             r_dv   [NDIV+1];
    logic [RW-1:0]    r_dr   [NDIV+1];
    logic [QB-1:0]    r_dn   [NDIV+1];
    logic [QB-1:0]    r_dq   [NDIV+1];
    logic [DW-1:0]    r_dd   [NDIV+1];
    logic             r_ddeg [NDIV+1];
    logic             r_dsat [NDIV+1];

    logic [NW-1:0]    c_num;
    logic [RW-1:0]    c_nhi;

    always_comb begin
        c_num = NW'(r7_cr2) << SH;
        c_nhi = RW'(c_num[NW-1:QB]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_fv[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dr[0]   <= c_nhi;
            r_dn[0]   <= c_num[QB-1:0];
            r_dq[0]   <= '0;
            r_dd[0]   <= r7_den;
            r_ddeg[0] <= r7_deg;
            r_dsat[0] <= c_nhi >= RW'(r7_den);
        end
    end

    for (genvar g = 1; g <= NDIV; g++) begin : g_div
        logic [RW-1:0] c_sh;
        logic          c_ge;

        always_comb begin
            c_sh = {r_dr[g-1][RW-2:0], r_dn[g-1][QB-1]};
            c_ge = c_sh >= RW'(r_dd[g-1]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[g] <= 1'b0;
            end else if (en) begin
                r_dv[g] <= r_dv[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dr[g]   <= c_ge ? c_sh - RW'(r_dd[g-1]) : c_sh;
                r_dn[g]   <= {r_dn[g-1][QB-2:0], 1'b0};
                r_dq[g]   <= {r_dq[g-1][QB-2:0], c_ge};
                r_dd[g]   <= r_dd[g-1];
                r_ddeg[g] <= r_ddeg[g-1];
                r_dsat[g] <= r_dsat[g-1];
            end
        end
    end

    // Square-root pipeline, one root bit per stage.
    logic             r_sv    [NSQ];
    logic [QB-1:0]    r_srad  [NSQ];
    logic [OUT_W-1:0] r_sroot [NSQ];
    logic [QB-1:0]    r_ssq   [NSQ];
    logic             r_sdeg  [NSQ];
    logic             r_ssat  [NSQ];

    for (genvar s = 0; s < NSQ; s++) begin : g_sqrt
        localparam int B = NSQ - 1 - s;
        logic             c_v;
        logic [QB-1:0]    c_rad;
        logic [OUT_W-1:0] c_root;
        logic [QB-1:0]    c_sq;
        logic             c_deg;
        logic             c_sat;
        logic [QB+1:0]    c_trial;
        logic             c_take;

        if (s == 0) begin : g_first
            assign c_v    = r_dv[NDIV];
            assign c_rad  = r_dq[NDIV];
            assign c_root = '0;
            assign c_sq   = '0;
            assign c_deg  = r_ddeg[NDIV];
            assign c_sat  = r_dsat[NDIV];
        end else begin : g_next
            assign c_v    = r_sv[s-1];
            assign c_rad  = r_srad[s-1];
            assign c_root = r_sroot[s-1];
            assign c_sq   = r_ssq[s-1];
            assign c_deg  = r_sdeg[s-1];
            assign c_sat  = r_ssat[s-1];
        end

        always_comb begin
            c_trial = (QB+2)'(c_sq) + ((QB+2)'(c_root) << (B + 1))
                    + ((QB+2)'(1) << (2 * B));
            c_take  = c_trial <= (QB+2)'(c_rad);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s] <= 1'b0;
            end else if (en) begin
                r_sv[s] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_srad[s]  <= c_rad;
                r_sroot[s] <= c_take ? (c_root | (OUT_W'(1) << B)) : c_root;
                r_ssq[s]   <= c_take ? QB'(c_trial) : c_sq;
                r_sdeg[s]  <= c_deg;
                r_ssat[s]  <= c_sat;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_sv[NSQ-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_sdeg[NSQ-1]) begin
                r_out_data <= '0;
            end else if (r_ssat[NSQ-1]) begin
                r_out_data <= '1;
            end else begin
                r_out_data <= r_sroot[NSQ-1];
            end
            r_out_user[USER_DEGEN] <= r_sdeg[NSQ-1];
            r_out_user[USER_SAT]   <= r_ssat[NSQ-1] && !r_sdeg[NSQ-1];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== sv/tpc_checker.sv =====
// Port-level checker for the three-point curvature core, bound into every instance of the core.
// Depends on tpc_pkg and three_point_curvature_core.
module tpc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [tpc_pkg::OUT_W-1:0]           m_axis_tdata,
    input logic [tpc_pkg::USER_W-1:0]          m_axis_tuser
);
    import tpc_pkg::*;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[USER_DEGEN] && m_axis_tuser[USER_SAT]))
        else $error("degenerate and saturated both set");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[USER_DEGEN]) |-> (m_axis_tdata == '0))
        else $error("degenerate result with nonzero curvature");

    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[USER_SAT]) |-> (m_axis_tdata == '1))
        else $error("saturated result not at full scale");

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output transfer changed");

endmodule

bind three_point_curvature_core tpc_checker u_tpc_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for three_point_curvature_core: streams point triples
// and compares every curvature transfer with an exact wide-integer predictor.
// Depends on tpc_pkg and three_point_curvature_core.
module tb_top;
    import tpc_pkg::*;

    localparam int CW    = COORD_WIDTH_DEF;
    localparam int FB    = FRAC_BITS_DEF;
    localparam int DW    = ((6*CW+7)/8)*8;
    localparam int WIDE  = 400;
    localparam int NRAND = 1330;

    typedef struct {
        logic [OUT_W-1:0] curv;
        logic             degen;
        logic             sat;
    } t_curv_result;

    class curvature_board;
        t_curv_result pending[$];
        int           errors;
        int           n_degen;
        int           n_sat;
        int           n_checked;

        function logic [WIDE-1:0] sq_len(longint dx, longint dy);
            logic signed [WIDE-1:0] sx;
            logic signed [WIDE-1:0] sy;
            sx = dx;
            sy = dy;
            return sx * sx + sy * sy;
        endfunction

        function void note(logic [DW-1:0] data);
            longint fx, fy, mx, my, lx, ly;
            longint d1x, d1y, d2x, d2y;
            logic signed [WIDE-1:0] wa, wb, wc, wd, cr;
            logic [WIDE-1:0] num, den, trial;
            logic [31:0] q;
            t_curv_result r;
            fx = longint'($signed(data[0*CW +: CW]));
            fy = longint'($signed(data[1*CW +: CW]));
            mx = longint'($signed(data[2*CW +: CW]));
            my = longint'($signed(data[3*CW +: CW]));
            lx = longint'($signed(data[4*CW +: CW]));
            ly = longint'($signed(data[5*CW +: CW]));
            d1x = mx - fx; d1y = my - fy;
            d2x = lx - fx; d2y = ly - fy;
            wa = d1x; wb = d2y; wc = d1y; wd = d2x;
            cr = wa * wb - wc * wd;
            if (cr < 0)
                cr = -cr;
            r = '{curv: '0, degen: 1'b0, sat: 1'b0};
            if (cr == 0) begin
                r.degen = 1'b1;
                n_degen++;
            end else begin
                num = (cr * cr) << (4*FB + 2);
                den = sq_len(d1x, d1y) * sq_len(lx - mx, ly - my) * sq_len(d2x, d2y);
                if ((den << 64) <= num) begin
                    r.curv = '1;
                    r.sat  = 1'b1;
                    n_sat++;
                end else begin
                    q = '0;
                    for (int b = 31; b >= 0; b--) begin
                        trial = WIDE'(q | (32'd1 << b));
                        if (trial * trial * den <= num)
                            q[b] = 1'b1;
                    end
                    r.curv = q;
                end
            end
            pending = {pending, r};
        endfunction

        function void check(logic [OUT_W-1:0] curv, logic [USER_W-1:0] user);
            t_curv_result e;
            n_checked++;
            if (pending.size() == 0) begin
                $error("unexpected result transfer: curvature %h", curv);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (curv !== e.curv) begin
                $error("curvature: expected %h, got %h", e.curv, curv);
                errors++;
            end
            if (user[USER_DEGEN] !== e.degen) begin
                $error("degenerate: expected %b, got %b", e.degen, user[USER_DEGEN]);
                errors++;
            end
            if (user[USER_SAT] !== e.sat) begin
                $error("saturated: expected %b, got %b", e.sat, user[USER_SAT]);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // first_x, first_y, middle_x, middle_y, last_x, last_y, zero fill
    logic [DW-1:0]     s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // curvature
    logic [OUT_W-1:0]  m_axis_tdata;
    // degenerate, saturated
    logic [USER_W-1:0] m_axis_tuser;

    curvature_board board = new();
    int             burst_left = 0;
    int             sent = 0;

    three_point_curvature_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check(m_axis_tdata, m_axis_tuser);
    end

    // The receiver cycles through always-ready, random and mostly-stalled stretches.
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    task automatic send_points(logic [CW-1:0] fx, logic [CW-1:0] fy, logic [CW-1:0] mx,
                               logic [CW-1:0] my, logic [CW-1:0] lx, logic [CW-1:0] ly);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ly, lx, my, mx, fy, fx};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic send_random();
        logic [CW-1:0] bx, by, dx, dy;
        int            kind, k;
        int            span;
        kind = $urandom_range(0, 9);
        bx = $urandom();
        by = $urandom();
        if (kind < 2) begin
            send_points($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        end else if (kind == 2) begin
            // Collinear: the third point lies on the line through the first two.
            dx = $signed(CW'($urandom_range(0, 4095))) - 2048;
            dy = $signed(CW'($urandom_range(0, 4095))) - 2048;
            k = $urandom_range(0, 20) - 10;
            send_points(bx, by, bx + dx, by + dy, bx + dx*k, by + dy*k);
        end else if (kind == 3) begin
            // Coincident points, all or two of them.
            if ($urandom_range(0, 1))
                send_points(bx, by, bx, by, bx, by);
            else
                send_points(bx, by, bx, by, $urandom(), $urandom());
        end else begin
            // Small triangle around a random base, at a random scale.
            span = 1 << $urandom_range(0, 28);
            send_points(bx + CW'($urandom_range(0, span)), by + CW'($urandom_range(0, span)),
                        bx + CW'($urandom_range(0, span)), by + CW'($urandom_range(0, span)),
                        bx + CW'($urandom_range(0, span)), by + CW'($urandom_range(0, span)));
        end
    endtask

    localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE  = CW'(1) << FB;

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_points('0, '0, '0, '0, '0, '0);
        send_points('0, '0, ONE, '0, '0, ONE);
        send_points('0, '0, ONE, ONE, 2*ONE, 2*ONE);
        send_points(MAXC, MAXC, MINC, MINC, MAXC, MINC);
        send_points(MINC, MINC, MAXC, MINC, MINC, MAXC);
        send_points(MINC, MAXC, MAXC, MINC, '0, '0);
        send_points(MINC, MINC, '0, '0, MAXC, MAXC);
        send_points('1, '1, '1, '1, '1, '1);
        send_points('0, '0, 1, '0, '0, 1);
        send_points(MAXC, MAXC, MAXC - 1, MAXC, MAXC, MAXC - 1);
        send_points(MINC, MINC, MINC + 1, MINC, MINC, MINC + 1);
        send_points('0, '0, 4, '0, 2, 1);
        send_points('0, '0, MAXC, '0, MAXC, 1);
        send_points(MINC, '0, MAXC, '0, '0, 1);
        send_points(MINC, '0, MAXC, '0, '0, MAXC);
        send_points('0, '0, ONE, '0, ONE, ONE);
        send_points(5, 7, 5, 7, 9, 3);
        send_points(-ONE, -ONE, ONE, -ONE, ONE, ONE);
        send_points(MAXC, '0, '0, MAXC, MINC, '0);
        send_points(3*ONE, 4*ONE, '0, '0, 3*ONE, '0);

        repeat (NRAND) send_random();
        s_axis_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);

        $display("Covered %0d point triples: %0d degenerate and %0d saturated expected.",
                 sent, board.n_degen, board.n_sat);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(12 * 3000000);
        $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== three_point_curvature_core.f =====
sv/tpc_pkg.sv
sv/three_point_curvature_core.sv
sv/tpc_checker.sv
bench/tb_top.sv
